/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* hw/rtl/lmfs_pkg.sv */
package lmfs_pkg;

   localparam int ROWS       = 8;
   localparam int ROW_IDX_W  = $clog2(ROWS);
   localparam int ROW_W      = 24;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int FRAME_W    = 48;
   localparam int MAX_WORDS  = FRAME_W / WORD_W;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 32;

   localparam logic [BYTE_W-1:0] WIDE_MASK   = 8'hF0;
   localparam logic [BYTE_W-1:0] NARROW_MASK = 8'hE0;

   localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_BCAST   = 2'd3;

   // input item payload, last field in the lowest bits
   typedef struct packed {
      logic [2:0]           pad;
      logic [BYTE_W-1:0]    reg_value;
      logic [3:0]           reg_opcode;
      logic                 wide_glyph;
      logic [BYTE_W-1:0]    glyph_row;
      logic [4:0]           x_pos;
      logic [ROW_IDX_W-1:0] row;
   } req_data_type;

   typedef struct packed {
      logic                 draw_we;
      logic                 clear;
      logic                 capture;
      logic                 load_refresh;
      logic                 load_bcast;
      logic                 last;
      logic [ROW_IDX_W-1:0] row_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

/* hw/rtl/led_matrix_framebuffer_serializer.sv */
// refresh: once accepted, 8 frames at one per cycle while rsp is not held, from the output register,
// limited by the single frame buffer read port; no new request is taken until the last frame is loaded
// broadcast: one frame per item, no new request taken until it is loaded; draw and clear: no result
// a frame appears on rsp in the cycle after it is built; a held output stalls the row walk
// reset (synchronous) clears the frame buffer, the controller and the output valid at once
module led_matrix_framebuffer_serializer #(
   parameter int DEVICES = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // row[2:0], x_pos[7:3], glyph_row[15:8], wide_glyph[16], reg_opcode[20:17],
   // reg_value[28:21], pad[31:29]
   input  logic [lmfs_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [lmfs_pkg::CMD_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame[47:0]
   output logic [lmfs_pkg::FRAME_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast
);
   import lmfs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lmfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lmfs_datapath #(
      .DEVICES (DEVICES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/lmfs_datapath.sv */
`include "assert_macros.svh"

module lmfs_datapath #(
   parameter int DEVICES = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lmfs_pkg::dp_cmd_type          cmd,
   output lmfs_pkg::dp_status_type       status,
   input  logic [lmfs_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lmfs_pkg::FRAME_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);
   import lmfs_pkg::*;

   localparam int WORDS = (DEVICES < MAX_WORDS) ? DEVICES : MAX_WORDS;

   req_data_type         req;
   logic [ROW_W-1:0]     fb_ff [ROWS];
   logic [ROW_IDX_W-1:0] rd_addr;
   logic [ROW_W-1:0]     rd_row;
   logic [ROW_W-1:0]     draw_mask;
   logic [ROW_W-1:0]     draw_bits;
   logic [ROW_W-1:0]     merged;
   logic [3:0]           opcode_ff;
   logic [BYTE_W-1:0]    value_ff;
   logic [BYTE_W-1:0]    op_byte;
   logic [FRAME_W-1:0]   frame;
   logic                 load;
   logic                 rsp_valid_ff;
   logic [FRAME_W-1:0]   rsp_data_ff;
   logic                 rsp_last_ff;

   assign req = req_data_type'(req_tdata);

   // one read port, shared by draw merge and refresh
   assign rd_addr = cmd.draw_we ? req.row : cmd.row_idx;
   assign rd_row  = fb_ff[rd_addr];

   // offsets of 24 or more shift everything out
   assign draw_mask = {(req.wide_glyph ? WIDE_MASK : NARROW_MASK), 16'h0000} >> req.x_pos;
   assign draw_bits = ({req.glyph_row, 16'h0000} >> req.x_pos) & draw_mask;
   assign merged    = (rd_row & ~draw_mask) | draw_bits;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int r = 0; r < ROWS; r++) begin
            fb_ff[r] <= '0;
         end
      end else if (cmd.draw_we) begin
         fb_ff[req.row] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req.reg_opcode;
         value_ff  <= req.reg_value;
      end
   end

   assign op_byte = cmd.load_bcast ? {4'b0000, opcode_ff}
                                   : BYTE_W'({1'b0, cmd.row_idx} + 4'd1);

   // words above the frame width are dropped
   always_comb begin
      frame = '0;
      for (int d = 0; d < WORDS; d++) begin
         frame[d*WORD_W +: WORD_W] = {op_byte,
                                      (cmd.load_bcast ? value_ff : rd_row[d*BYTE_W +: BYTE_W])};
      end
   end

   assign load            = cmd.load_refresh || cmd.load_bcast;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= frame;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_NEVER(a_no_overwrite, clock, reset, load && rsp_valid_ff && !rsp_tready,
      "frame loaded over an untaken item")
   `ASSERT_NEVER(a_one_load, clock, reset, cmd.load_refresh && cmd.load_bcast,
      "refresh and broadcast loads collide")

endmodule

/* hw/rtl/lmfs_ctrl.sv */
`include "assert_macros.svh"

module lmfs_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lmfs_pkg::CMD_W-1:0]   req_tuser,
   input  lmfs_pkg::dp_status_type      status,
   output lmfs_pkg::dp_cmd_type         cmd
);
   import lmfs_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_REFRESH = 2'd1;
   localparam logic [1:0] ST_BCAST   = 2'd2;

   localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(ROWS - 1);

   logic [1:0]           state_ff, state_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic                 accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      cmd      = '0;
      cmd.row_idx = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_tuser)
                  CMD_DRAW:    cmd.draw_we = 1'b1;
                  CMD_CLEAR:   cmd.clear   = 1'b1;
                  CMD_REFRESH: begin
                     state_in = ST_REFRESH;
                     row_in   = '0;
                  end
                  CMD_BCAST:   state_in = ST_BCAST;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_REFRESH: begin
            if (status.rsp_free) begin
               cmd.load_refresh = 1'b1;
               cmd.last         = (row_ff == LAST_ROW);
               row_in           = row_ff + 1'b1;
               if (row_ff == LAST_ROW) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BCAST: begin
            if (status.rsp_free) begin
               cmd.load_bcast = 1'b1;
               cmd.last       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   `ASSERT_CLK(a_refresh_start, clock, reset,
      (accept && req_tuser == CMD_REFRESH) |=> (state_ff == ST_REFRESH && row_ff == '0),
      "refresh did not start at row zero")
   `ASSERT_CLK(a_refresh_end, clock, reset,
      (state_ff == ST_REFRESH && cmd.load_refresh && row_ff == LAST_ROW) |=> (state_ff == ST_IDLE),
      "refresh did not end after the last row")

endmodule
